// ----- rtl/sbem_pkg.sv -----
// Shared constants, types and command struct of the sized big-endian byte memory.
`timescale 1ns / 1ps
`default_nettype none
package sbem_pkg;

   localparam int MEM_BYTES      = 4096;
   localparam int BYTES_PER_WORD = 4;
   localparam int NUM_BANKS      = BYTES_PER_WORD;
   localparam int BANK_ROWS      = MEM_BYTES / NUM_BANKS;
   localparam int ROW_W          = $clog2(BANK_ROWS);
   localparam int ADDR_W         = 16;
   localparam int DATA_W         = 32;

   typedef logic [ADDR_W:0]   addr_ext_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [7:0]        byte_type;
   typedef logic [DATA_W-1:0] data_type;

   localparam addr_ext_type MEM_LIMIT = addr_ext_type'(MEM_BYTES);

   // Access kinds.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // word accepted: latch it and run the bank access
      logic load;      // bank read data valid: update the held read word
   } sbem_cmd_type;

endpackage
`default_nettype wire

// ----- rtl/sbem_if.sv -----
// Request and response channel interfaces of the sized big-endian byte memory.
`timescale 1ns / 1ps
`default_nettype none
interface sbem_req_if;
   import sbem_pkg::*;
   logic             valid;
   logic             ready;
   logic             op;
   logic [ADDR_W-1:0] address;
   logic [1:0]       size_code;
   data_type         write_data;

   modport source (output valid, op, address, size_code, write_data, input ready);
   modport sink   (input valid, op, address, size_code, write_data, output ready);
endinterface

interface sbem_rsp_if;
   import sbem_pkg::*;
   logic     valid;
   logic     ready;
   data_type read_data;
   logic     in_range;

   modport source (output valid, read_data, in_range, input ready);
   modport sink   (input valid, read_data, in_range, output ready);
endinterface
`default_nettype wire

// ----- rtl/sbem_ctrl.sv -----
// Controller state machine: accepts a word, sequences the access, holds the response.
`timescale 1ns / 1ps
`default_nettype none
module sbem_ctrl
   import sbem_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output sbem_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      valid_in = valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               state_in = ST_LOAD;
               ready_in = 1'b0;
            end
         end
         ST_LOAD: begin
            state_in = ST_SEND;
            valid_in = 1'b1;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
               valid_in = 1'b0;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            valid_in = 1'b0;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready   = ready_ff;
   assign rsp_valid   = valid_ff;
   assign cmd.capture = req_valid && ready_ff;
   assign cmd.load    = (state_ff == ST_LOAD);

endmodule
`default_nettype wire

// ----- rtl/sbem_datapath.sv -----
// Datapath: four byte banks, range check, byte steering and the held read word.
`timescale 1ns / 1ps
`default_nettype none
module sbem_datapath
   import sbem_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sbem_cmd_type      cmd,
   input  wire logic              req_op,
   input  wire logic [ADDR_W-1:0] req_address,
   input  wire logic [1:0]        req_size_code,
   input  wire data_type          req_write_data,
   output data_type               rsp_read_data,
   output logic                   rsp_in_range
);

   byte_type     bank_mem [NUM_BANKS][BANK_ROWS];
   byte_type     rd_q     [NUM_BANKS];

   logic [2:0]   count;
   addr_ext_type end_addr;
   logic         fits;
   logic [1:0]   bank_k   [NUM_BANKS];
   logic [1:0]   bank_j   [NUM_BANKS];
   row_type      bank_row [NUM_BANKS];
   logic         bank_we  [NUM_BANKS];
   byte_type     bank_wd  [NUM_BANKS];

   logic         op_ff;
   logic [1:0]   addr_lo_ff;
   logic [2:0]   count_ff;
   logic         fits_ff;
   data_type     held_ff;
   data_type     assembled;

   // Byte k of the access (k = 0 is the most significant) lands in bank
   // (address + k) mod 4; banks below the start bank use the next row.
   always_comb begin
      count    = 3'd4 - {1'b0, req_size_code};
      end_addr = {1'b0, req_address} + {{(ADDR_W-2){1'b0}}, count};
      fits     = (end_addr <= MEM_LIMIT);
      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_k[b]   = 2'(b) - req_address[1:0];
         bank_j[b]   = 2'(count - 3'd1 - {1'b0, bank_k[b]});
         bank_row[b] = req_address[ROW_W+1:2] + row_type'(2'(b) < req_address[1:0]);
         bank_we[b]  = cmd.capture && fits && (req_op == OP_WRITE) &&
                       ({1'b0, bank_k[b]} < count);
         bank_wd[b]  = 8'(req_write_data >> {bank_j[b], 3'b000});
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (cmd.capture) begin
            if (bank_we[b]) begin
               bank_mem[b][bank_row[b]] <= bank_wd[b];
            end
            rd_q[b] <= bank_mem[b][bank_row[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         addr_lo_ff <= req_address[1:0];
         count_ff   <= count;
         fits_ff    <= fits;
      end
   end

   always_comb begin
      assembled = '0;
      for (int i = 0; i < BYTES_PER_WORD; i++) begin
         if (3'(i) < count_ff) begin
            assembled = {assembled[DATA_W-9:0], rd_q[2'(addr_lo_ff + 2'(i))]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (cmd.load && fits_ff && (op_ff == OP_READ)) begin
         held_ff <= assembled;
      end
   end

   assign rsp_read_data = held_ff;
   assign rsp_in_range  = fits_ff;

endmodule
`default_nettype wire

// ----- rtl/sized_big_endian_byte_memory.sv -----
// Sized big-endian byte memory.
// A byte-addressed RAM of MEM_BYTES bytes, built from four byte-wide banks.
// The request channel carries one access per word: op (read or write), the
// byte address, a size code (0 four bytes, 1 three, 2 two, 3 one) and the
// write data. The lowest address holds the most significant byte.
// The response channel returns one word per access: the held read data and
// an in-range flag; an access that would run past the end is not performed.
// The bank read and the access registers are loaded when the request is
// accepted, the held read word is updated in the load state, and the response
// is valid in the send state; a new request is taken only after the response
// is delivered, so one access is in flight at a time.
// A stalled response holds its payload and blocks further requests.
// Reset clears the controller and the held read data; memory contents are
// undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module sized_big_endian_byte_memory
   import sbem_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   sbem_req_if.sink    req_chan,
   sbem_rsp_if.source  rsp_chan
);

   sbem_cmd_type cmd;

   sbem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   sbem_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_chan.op),
      .req_address    (req_chan.address),
      .req_size_code  (req_chan.size_code),
      .req_write_data (req_chan.write_data),
      .rsp_read_data  (rsp_chan.read_data),
      .rsp_in_range   (rsp_chan.in_range)
   );

`ifndef SYNTH
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a response is pending");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> ##2 rsp_chan.valid)
      else $error("response not valid two cycles after accept");

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready) |=> req_chan.ready)
      else $error("not ready after response delivered");

   a_write_keeps_held: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.op == OP_WRITE)) |-> ##2
      (rsp_chan.read_data == $past(rsp_chan.read_data, 2)))
      else $error("write changed the held read data");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/sbem_checker.sv -----
// Checker for the sized big-endian byte memory: mirrors the memory and compares every response.
`timescale 1ns / 1ps
module sbem_checker
   import sbem_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sbem_req_if  req_mon,
   sbem_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   typedef struct {
      data_type read_data;
      logic     in_range;
   } reply_type;

   byte_type  mem_image [MEM_BYTES];
   data_type  held_word;
   reply_type awaited_replies [$];
   int        errors;

   // Applies one access to the mirror and returns the response it must produce.
   function automatic reply_type apply_access(logic op, logic [ADDR_W-1:0] addr,
                                              logic [1:0] size_code, data_type wdata);
      int        span;
      int        i;
      bit        fits;
      data_type  word;
      reply_type reply;
      span = BYTES_PER_WORD - int'(size_code);
      fits = (int'(addr) + span) <= MEM_BYTES;
      if (fits) begin
         if (op == OP_WRITE) begin
            for (i = 0; i < span; i++)
               mem_image[int'(addr) + i] = byte_type'(wdata >> (8 * (span - 1 - i)));
         end else begin
            word = '0;
            for (i = 0; i < span; i++)
               word = (word << 8) | data_type'(mem_image[int'(addr) + i]);
            held_word = word;
         end
      end
      reply.read_data = held_word;
      reply.in_range  = fits;
      return reply;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         awaited_replies.delete();
         held_word = '0;
         errors    = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            awaited_replies.push_back(apply_access(req_mon.op, req_mon.address,
                                                   req_mon.size_code, req_mon.write_data));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_replies.size() == 0) begin
               $display("%0t: response word with no access outstanding, read_data %h in_range %b",
                        $time, rsp_mon.read_data, rsp_mon.in_range);
               errors++;
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_mon.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_mon.read_data);
                  errors++;
               end
               if (rsp_mon.in_range !== want.in_range) begin
                  $display("%0t: in_range expected %b actual %b",
                           $time, want.in_range, rsp_mon.in_range);
                  errors++;
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= awaited_replies.size();
   end

endmodule

// ----- tb/sv/tb_sized_big_endian_byte_memory.sv -----
// Testbench top for the sized big-endian byte memory: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_sized_big_endian_byte_memory
   import sbem_pkg::*;
;

   localparam logic [1:0] SIZE_WORD   = 2'd0;
   localparam logic [1:0] SIZE_TRIPLE = 2'd1;
   localparam logic [1:0] SIZE_HALF   = 2'd2;
   localparam logic [1:0] SIZE_BYTE   = 2'd3;

   localparam int RANDOM_ACCESSES = 900;
   localparam int CALM_TAIL       = 150;
   localparam int HOLD_AFTER      = 300;
   localparam int HOLD_CYCLES     = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   sent_count;
   bit   calm_tail;
   bit   byte_written [MEM_BYTES];

   sbem_req_if req_chan ();
   sbem_rsp_if rsp_chan ();

   sized_big_endian_byte_memory dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sbem_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("tb_sized_big_endian_byte_memory failed");
      $finish;
   end

   function automatic bit fits_memory(logic [ADDR_W-1:0] addr, logic [1:0] size_code);
      return (int'(addr) + BYTES_PER_WORD - int'(size_code)) <= MEM_BYTES;
   endfunction

   function automatic bit span_written(logic [ADDR_W-1:0] addr, logic [1:0] size_code);
      int i;
      for (i = 0; i < BYTES_PER_WORD - int'(size_code); i++)
         if (!byte_written[int'(addr) + i])
            return 1'b0;
      return 1'b1;
   endfunction

   task automatic send_access(logic op, logic [ADDR_W-1:0] addr, logic [1:0] size_code,
                              data_type wdata);
      int i;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.address    <= addr;
      req_chan.size_code  <= size_code;
      req_chan.write_data <= wdata;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
      if (op == OP_WRITE && fits_memory(addr, size_code))
         for (i = 0; i < BYTES_PER_WORD - int'(size_code); i++)
            byte_written[int'(addr) + i] = 1'b1;
   endtask

   task automatic random_access();
      logic              op;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        size_code;
      int                pick;
      pick      = $urandom_range(0, 99);
      size_code = 2'($urandom_range(0, 3));
      op        = 1'($urandom_range(0, 1));
      if (pick < 10)
         addr = ADDR_W'($urandom_range(MEM_BYTES - 3, 65535));
      else if (pick < 60)
         addr = ADDR_W'($urandom_range(0, 127));
      else if (pick < 80)
         addr = ADDR_W'($urandom_range(MEM_BYTES - 128, MEM_BYTES - 1));
      else
         addr = ADDR_W'($urandom_range(0, MEM_BYTES - 1));
      // Memory is undefined until written, so a read of a fresh span becomes a write to it.
      if (op == OP_READ && fits_memory(addr, size_code) && !span_written(addr, size_code))
         op = OP_WRITE;
      send_access(op, addr, size_code, $urandom);
   endtask

   // Response side: random stalls, one long hold-off to back up the request side,
   // and always ready during the calm tail.
   initial begin
      bit held_once;
      rsp_chan.ready <= 1'b0;
      forever begin
         if (calm_tail) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else if (!held_once && sent_count >= HOLD_AFTER) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held_once = 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   initial begin
      int n;
      req_chan.valid      <= 1'b0;
      req_chan.op         <= OP_READ;
      req_chan.address    <= '0;
      req_chan.size_code  <= SIZE_WORD;
      req_chan.write_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Past the end before anything is written: the held word is still zero.
      send_access(OP_READ,  16'd4093,  SIZE_WORD,   32'h0000_0000);
      send_access(OP_WRITE, 16'd0,     SIZE_WORD,   32'hFFFF_FFFF);
      send_access(OP_READ,  16'd0,     SIZE_WORD,   32'h0000_0000);
      send_access(OP_WRITE, 16'd0,     SIZE_BYTE,   32'h1234_5600);
      send_access(OP_READ,  16'd0,     SIZE_WORD,   32'hFFFF_FFFF);
      send_access(OP_WRITE, 16'd1,     SIZE_TRIPLE, 32'hABA1_B2C3);
      send_access(OP_READ,  16'd0,     SIZE_HALF,   32'h0000_0000);
      send_access(OP_READ,  16'd1,     SIZE_TRIPLE, 32'h0000_0000);
      // Last word of memory, then every size that ends exactly at the top.
      send_access(OP_WRITE, 16'd4092,  SIZE_WORD,   32'h89AB_CDEF);
      send_access(OP_READ,  16'd4095,  SIZE_BYTE,   32'hFFFF_FFFF);
      send_access(OP_READ,  16'd4094,  SIZE_HALF,   32'h0000_0000);
      send_access(OP_READ,  16'd4093,  SIZE_TRIPLE, 32'h0000_0000);
      send_access(OP_READ,  16'd4093,  SIZE_WORD,   32'h0000_0000);
      // A write that runs one byte past the end must leave memory untouched.
      send_access(OP_WRITE, 16'd4094,  SIZE_TRIPLE, 32'h0000_0000);
      send_access(OP_READ,  16'd4092,  SIZE_WORD,   32'h0000_0000);
      send_access(OP_WRITE, 16'd65535, SIZE_BYTE,   32'h0000_005A);
      send_access(OP_READ,  16'd65532, SIZE_WORD,   32'h0000_0000);
      send_access(OP_WRITE, 16'd4096,  SIZE_BYTE,   32'h0000_00A5);
      send_access(OP_WRITE, 16'd2,     SIZE_HALF,   32'hFFFF_0000);
      send_access(OP_READ,  16'd0,     SIZE_WORD,   32'h0000_0000);
      send_access(OP_WRITE, 16'd0,     SIZE_WORD,   32'h0000_0000);
      send_access(OP_READ,  16'd0,     SIZE_WORD,   32'hFFFF_FFFF);
      send_access(OP_WRITE, 16'h0800,  SIZE_WORD,   32'h5555_AAAA);
      send_access(OP_READ,  16'h0800,  SIZE_WORD,   32'h0000_0000);

      for (n = 0; n < RANDOM_ACCESSES; n++) begin
         if (n == RANDOM_ACCESSES - CALM_TAIL)
            calm_tail = 1'b1;
         random_access();
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("tb_sized_big_endian_byte_memory passed");
      else
         $display("tb_sized_big_endian_byte_memory failed");
      $finish;
   end

endmodule
